// File: hw/rtl/deo_pkg.sv
// ----------------------------------------------------------------------------
// Deflate offer parser package
// Parse phases, word constants and the result record shared by the parser
// and its testbench.
// ----------------------------------------------------------------------------
package deo_pkg;

  // Parse phases of the extensions header value.
  typedef enum logic [2:0] {
    PH_EXT_NAME   = 3'd0,
    PH_EXT_SKIP   = 3'd1,
    PH_PRM_NAME   = 3'd2,
    PH_VAL_LEAD   = 3'd3,
    PH_VAL_DIGITS = 3'd4,
    PH_PRM_SKIP   = 3'd5,
    PH_DONE       = 3'd6
  } ph_e;

  // Window parameter whose value is being read.
  typedef enum logic [1:0] {
    WIN_NONE = 2'd0,
    WIN_SRV  = 2'd1,
    WIN_CLI  = 2'd2
  } win_sel_e;

  // One result transaction.
  typedef struct packed {
    logic       offer_found;
    logic       server_keeps_no_context;
    logic       client_keeps_no_context;
    logic [3:0] server_window_bits;
    logic [3:0] client_window_bits;
  } res_t;

  // Byte codes.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Name lengths and counter limits.
  localparam logic [4:0] EXT_LEN  = 5'd18;
  localparam logic [4:0] FLAG_LEN = 5'd26;
  localparam logic [4:0] WIN_LEN  = 5'd22;
  localparam logic [4:0] POS_MAX  = 5'd31;
  localparam logic [4:0] ACC_MAX  = 5'd31;
  localparam logic [4:0] WIN_MIN  = 5'd8;
  localparam logic [4:0] WIN_MAX  = 5'd15;
  localparam logic [3:0] WIN_DEF  = 4'd15;
  localparam logic [4:0] ALL_CAND = 5'b11111;

  // Words, right aligned in a field wide enough for the longest one.
  localparam int WORD_W = 8 * 26;
  localparam logic [WORD_W-1:0] EXT_WORD      = WORD_W'("permessage-deflate");
  localparam logic [WORD_W-1:0] SRV_FLAG_WORD = WORD_W'({"server_no_", "context_takeover"});
  localparam logic [WORD_W-1:0] CLI_FLAG_WORD = WORD_W'({"client_no_", "context_takeover"});
  localparam logic [WORD_W-1:0] SRV_WIN_WORD  = WORD_W'({"server_max_", "window_bits"});
  localparam logic [WORD_W-1:0] CLI_WIN_WORD  = WORD_W'({"client_max_", "window_bits"});

  // True when the word has the given lowercase byte at the given position.
  function automatic logic word_hit(input logic [WORD_W-1:0] word, input logic [4:0] len,
                                    input logic [4:0] pos, input logic [7:0] ch);
    logic hit;
    int   idx;
    hit = 1'b0;
    idx = int'(len) - 1 - int'(pos);
    if (pos < len) begin
      hit = (word[8*idx +: 8] == ch);
    end
    return hit;
  endfunction

endpackage

// File: hw/rtl/deo_if.sv
// ----------------------------------------------------------------------------
// Deflate offer parser channels
// Valid/ready channels for header bytes and for parse results.
// ----------------------------------------------------------------------------

// Header byte channel.
interface deo_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_byte;

  modport source (output valid, output char_in, output last_byte, input ready);
  modport sink (input valid, input char_in, input last_byte, output ready);
endinterface

// Parse result channel.
interface deo_result_if;
  logic       valid;
  logic       ready;
  logic       offer_found;
  logic       server_keeps_no_context;
  logic       client_keeps_no_context;
  logic [3:0] server_window_bits;
  logic [3:0] client_window_bits;

  modport source (output valid, output offer_found, output server_keeps_no_context,
                  output client_keeps_no_context, output server_window_bits,
                  output client_window_bits, input ready);
  modport sink (input valid, input offer_found, input server_keeps_no_context,
                input client_keeps_no_context, input server_window_bits,
                input client_window_bits, output ready);
endinterface

// File: hw/rtl/deflate_extension_offer_parser.sv
// ----------------------------------------------------------------------------
// Deflate extension offer parser
// Streams an extensions header value one byte per transaction and reports
// the first permessage-deflate offer with its parameters on the last byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result queue is not full; the
// parser state updates in the cycle a byte is accepted.
// The result is written into the result queue when the last byte is accepted.
// A two-entry result queue lets bytes flow while one result waits.
// Reset: parser state returns to the start of an extension name and the
// result queue empties; the state also restarts after every last byte.
module deflate_extension_offer_parser
  import deo_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  deo_byte_if.sink     byte_i,
  deo_result_if.source result_o
);

  // Parser state.
  ph_e        ph_q, ph_d, ph_m;
  logic [4:0] pos_q, pos_d, pos_m;
  logic [4:0] cand_q, cand_d, cand_m;
  logic       isp_q, isp_d, isp_m;
  win_sel_e   which_q, which_d, which_m;
  logic [4:0] acc_q, acc_d, acc_m;
  logic       found_q, found_d, found_m;
  logic [1:0] tk_q, tk_d, tk_m;
  logic [3:0] win_srv_q, win_srv_d, win_srv_m;
  logic [3:0] win_cli_q, win_cli_d, win_cli_m;

  // Result queue.
  res_t       res_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  res_t       res_new;

  logic       accept, push, pop;
  logic [7:0] ch, lc;
  logic       is_comma, is_semi, is_equal, is_blank, is_digit;
  logic [3:0] digit;
  logic [8:0] acc_mul;
  logic [4:0] acc_sat;
  logic       ext_ok;
  logic [3:0] prm_ok;
  logic [4:0] cand_nc, pos_nc;
  logic       ext_match, srv_flag, cli_flag, srv_win, cli_win, win_ok;

  // Handshake.
  assign byte_i.ready = (cnt_q != 2'd2);
  assign accept       = byte_i.valid & byte_i.ready;
  assign push         = accept & byte_i.last_byte;
  assign pop          = result_o.valid & result_o.ready;

  // Byte classes.
  assign ch       = byte_i.char_in;
  assign lc       = (ch >= CH_UP_A && ch <= CH_UP_Z) ? ch + CASE_OFS : ch;
  assign is_comma = (ch == CH_COMMA);
  assign is_semi  = (ch == CH_SEMI);
  assign is_equal = (ch == CH_EQUAL);
  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit    = 4'(ch - CH_ZERO);

  // Saturating decimal accumulation.
  assign acc_mul = 9'(acc_q) * 9'd10 + 9'(digit);
  assign acc_sat = (acc_mul > 9'(ACC_MAX)) ? ACC_MAX : acc_mul[4:0];

  // Name comparison against each candidate word.
  assign ext_ok    = word_hit(EXT_WORD, EXT_LEN, pos_q, lc);
  assign prm_ok[0] = word_hit(SRV_FLAG_WORD, FLAG_LEN, pos_q, lc);
  assign prm_ok[1] = word_hit(CLI_FLAG_WORD, FLAG_LEN, pos_q, lc);
  assign prm_ok[2] = word_hit(SRV_WIN_WORD, WIN_LEN, pos_q, lc);
  assign prm_ok[3] = word_hit(CLI_WIN_WORD, WIN_LEN, pos_q, lc);

  always_comb begin
    if (isp_q) begin
      cand_nc = '0;
    end else if (ph_q == PH_EXT_NAME) begin
      cand_nc = cand_q & {4'b1111, ext_ok};
    end else begin
      cand_nc = cand_q & {1'b1, prm_ok};
    end
  end

  assign pos_nc = (pos_q < POS_MAX) ? pos_q + 5'd1 : pos_q;

  // Completed-name matches on the current state.
  assign ext_match = cand_q[0] && (pos_q == EXT_LEN);
  assign srv_flag  = cand_q[0] && (pos_q == FLAG_LEN);
  assign cli_flag  = cand_q[1] && (pos_q == FLAG_LEN);
  assign srv_win   = cand_q[2] && (pos_q == WIN_LEN);
  assign cli_win   = cand_q[3] && (pos_q == WIN_LEN);
  assign win_ok    = (acc_q >= WIN_MIN) && (acc_q <= WIN_MAX);

  // Next parse phase after this byte, then restart after the last byte.
  always_comb begin
    ph_m = ph_q;
    case (ph_q)
      PH_EXT_NAME: begin
        if (is_comma) begin
          ph_m = ext_match ? PH_DONE : PH_EXT_NAME;
        end else if (is_semi) begin
          ph_m = ext_match ? PH_PRM_NAME : PH_EXT_SKIP;
        end
      end
      PH_EXT_SKIP: begin
        if (is_comma) ph_m = PH_EXT_NAME;
      end
      PH_PRM_NAME: begin
        if (is_comma) begin
          ph_m = PH_DONE;
        end else if (is_semi) begin
          ph_m = PH_PRM_NAME;
        end else if (is_equal) begin
          ph_m = (srv_win || cli_win) ? PH_VAL_LEAD : PH_PRM_SKIP;
        end
      end
      PH_VAL_LEAD, PH_VAL_DIGITS: begin
        if (is_digit) begin
          ph_m = PH_VAL_DIGITS;
        end else if (!(is_blank && ph_q == PH_VAL_LEAD)) begin
          if (is_comma) ph_m = PH_DONE;
          else if (is_semi) ph_m = PH_PRM_NAME;
          else ph_m = PH_PRM_SKIP;
        end
      end
      PH_PRM_SKIP: begin
        if (is_comma) ph_m = PH_DONE;
        else if (is_semi) ph_m = PH_PRM_NAME;
      end
      default: ph_m = ph_q;
    endcase
    ph_d = byte_i.last_byte ? PH_EXT_NAME : ph_m;
  end

  // Datapath update: name tracking, flags, values and the final result.
  always_comb begin
    pos_m     = pos_q;
    cand_m    = cand_q;
    isp_m     = isp_q;
    which_m   = which_q;
    acc_m     = acc_q;
    found_m   = found_q;
    tk_m      = tk_q;
    win_srv_m = win_srv_q;
    win_cli_m = win_cli_q;

    case (ph_q)
      PH_EXT_NAME: begin
        if (is_comma || is_semi) begin
          if (ext_match) found_m = 1'b1;
          if (is_comma != ext_match) begin
            pos_m  = '0;
            cand_m = ALL_CAND;
            isp_m  = 1'b0;
          end
        end else if (is_blank) begin
          if (pos_q != '0) isp_m = 1'b1;
        end else begin
          cand_m = cand_nc;
          pos_m  = pos_nc;
        end
      end
      PH_EXT_SKIP: begin
        if (is_comma) begin
          pos_m  = '0;
          cand_m = ALL_CAND;
          isp_m  = 1'b0;
        end
      end
      PH_PRM_NAME: begin
        if (is_comma || is_semi || is_equal) begin
          tk_m = tk_q | {cli_flag, srv_flag};
          if (is_semi) begin
            pos_m  = '0;
            cand_m = ALL_CAND;
            isp_m  = 1'b0;
          end
          if (is_equal) begin
            acc_m = '0;
            if (srv_win) which_m = WIN_SRV;
            else if (cli_win) which_m = WIN_CLI;
            else which_m = WIN_NONE;
          end
        end else if (is_blank) begin
          if (pos_q != '0) isp_m = 1'b1;
        end else begin
          cand_m = cand_nc;
          pos_m  = pos_nc;
        end
      end
      PH_VAL_LEAD, PH_VAL_DIGITS: begin
        if (is_digit) begin
          acc_m = (ph_q == PH_VAL_LEAD) ? 5'(digit) : acc_sat;
        end else if (!(is_blank && ph_q == PH_VAL_LEAD)) begin
          if (win_ok && which_q == WIN_SRV) win_srv_m = acc_q[3:0];
          if (win_ok && which_q == WIN_CLI) win_cli_m = acc_q[3:0];
          which_m = WIN_NONE;
          acc_m   = '0;
          if (is_semi) begin
            pos_m  = '0;
            cand_m = ALL_CAND;
            isp_m  = 1'b0;
          end
        end
      end
      PH_PRM_SKIP: begin
        if (is_semi) begin
          pos_m  = '0;
          cand_m = ALL_CAND;
          isp_m  = 1'b0;
        end
      end
      default: ;
    endcase

    // Close the value on the last byte.
    if (byte_i.last_byte) begin
      if (ph_m == PH_EXT_NAME) begin
        if (cand_m[0] && pos_m == EXT_LEN) found_m = 1'b1;
      end else if (ph_m == PH_PRM_NAME) begin
        tk_m = tk_m | {cand_m[1] && (pos_m == FLAG_LEN), cand_m[0] && (pos_m == FLAG_LEN)};
      end else if (ph_m == PH_VAL_DIGITS) begin
        if (acc_m >= WIN_MIN && acc_m <= WIN_MAX) begin
          if (which_m == WIN_SRV) win_srv_m = acc_m[3:0];
          if (which_m == WIN_CLI) win_cli_m = acc_m[3:0];
        end
      end
    end

    res_new.offer_found             = found_m;
    res_new.server_keeps_no_context = found_m & tk_m[0];
    res_new.client_keeps_no_context = found_m & tk_m[1];
    res_new.server_window_bits      = found_m ? win_srv_m : WIN_DEF;
    res_new.client_window_bits      = found_m ? win_cli_m : WIN_DEF;

    if (byte_i.last_byte) begin
      pos_d     = '0;
      cand_d    = ALL_CAND;
      isp_d     = 1'b0;
      which_d   = WIN_NONE;
      acc_d     = '0;
      found_d   = 1'b0;
      tk_d      = '0;
      win_srv_d = WIN_DEF;
      win_cli_d = WIN_DEF;
    end else begin
      pos_d     = pos_m;
      cand_d    = cand_m;
      isp_d     = isp_m;
      which_d   = which_m;
      acc_d     = acc_m;
      found_d   = found_m;
      tk_d      = tk_m;
      win_srv_d = win_srv_m;
      win_cli_d = win_cli_m;
    end
  end

  // Parser state registers, updated on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_EXT_NAME;
      pos_q     <= '0;
      cand_q    <= ALL_CAND;
      isp_q     <= 1'b0;
      which_q   <= WIN_NONE;
      acc_q     <= '0;
      found_q   <= 1'b0;
      tk_q      <= '0;
      win_srv_q <= WIN_DEF;
      win_cli_q <= WIN_DEF;
    end else if (accept) begin
      ph_q      <= ph_d;
      pos_q     <= pos_d;
      cand_q    <= cand_d;
      isp_q     <= isp_d;
      which_q   <= which_d;
      acc_q     <= acc_d;
      found_q   <= found_d;
      tk_q      <= tk_d;
      win_srv_q <= win_srv_d;
      win_cli_q <= win_cli_d;
    end
  end

  // Result queue occupancy.
  always_comb begin
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push) res_q[wr_ptr_q] <= res_new;
  end

  assign result_o.valid                   = (cnt_q != 2'd0);
  assign result_o.offer_found             = res_q[rd_ptr_q].offer_found;
  assign result_o.server_keeps_no_context = res_q[rd_ptr_q].server_keeps_no_context;
  assign result_o.client_keeps_no_context = res_q[rd_ptr_q].client_keeps_no_context;
  assign result_o.server_window_bits      = res_q[rd_ptr_q].server_window_bits;
  assign result_o.client_window_bits      = res_q[rd_ptr_q].client_window_bits;

`ifndef ASSERT_OFF
  // The queue never holds more than two results.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("result queue overflow");

  // A last byte always leaves the parser at the start of a new value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (ph_q == PH_EXT_NAME) && (pos_q == '0) && !found_q && (tk_q == '0))
    else $error("parser not restarted after last byte");

  // A missing offer reports default parameters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.offer_found) |->
      (result_o.server_window_bits == WIN_DEF) && (result_o.client_window_bits == WIN_DEF) &&
      !result_o.server_keeps_no_context && !result_o.client_keeps_no_context)
    else $error("defaults not reported without an offer");

  // Reported window sizes stay within the legal range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.server_window_bits >= WIN_MIN[3:0]) &&
                       (result_o.client_window_bits >= WIN_MIN[3:0]))
    else $error("window bits out of range");
`endif

endmodule

// File: verif/deflate_extension_offer_parser_tb.sv
// ----------------------------------------------------------------------------
// Deflate extension offer parser testbench
// Streams extensions header values through the parser one byte per
// transaction and checks every parse result against an in-bench parser.
// Header values are mostly well-formed offers with random case, blanks,
// parameters and values, mixed with truncated values and byte noise. The
// sender works in bursts and the receiver stalls on its own pattern,
// including one long hold-off that fills the result queue.
// ----------------------------------------------------------------------------
module deflate_extension_offer_parser_tb;
  import deo_pkg::*;

  localparam int RANDOM_BYTES   = 1050;
  localparam int MIN_HEADERS    = 40;
  localparam int IDLE_LIMIT     = 4000;
  localparam int HOLDOFF_AT     = 300;
  localparam int HOLDOFF_CYCLES = 500;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 40;

  // Word indexes; a parameter word shares its index with its candidate bit.
  localparam int WORD_SRV_FLAG = 0;
  localparam int WORD_CLI_FLAG = 1;
  localparam int WORD_SRV_WIN  = 2;
  localparam int WORD_CLI_WIN  = 3;
  localparam int WORD_OFFER    = 4;
  localparam int OFFER_BIT     = 0;

  // Extra byte codes used only to build stimulus.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] LOW_A    = 8'h61;
  localparam logic [7:0] LOW_Z    = 8'h7A;
  localparam logic [7:0] PRINT_LO = 8'h21;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } hdr_byte_t;

  logic clk_i;
  logic rst_ni;

  deo_byte_if   byte_ch ();
  deo_result_if result_ch ();

  deflate_extension_offer_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_ch),
    .result_o (result_ch)
  );

  hdr_byte_t   pending_bytes[$];
  res_t        expected_offers[$];
  logic [7:0]  hdr_bytes[$];
  hdr_byte_t   next_byte;
  res_t        oldest_offer;
  int          headers_built;
  int          bytes_accepted;
  int          total_bytes;
  int          error_count;

  // In-bench parser state.
  ph_e         parse_ph;
  logic [4:0]  name_pos;
  logic [4:0]  name_cands;
  logic        name_broken;
  win_sel_e    win_target;
  logic [4:0]  value_acc;
  logic        offer_seen;
  logic [1:0]  no_ctx_seen;
  logic [3:0]  srv_bits;
  logic [3:0]  cli_bits;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Header value parser
  // --------------------------------------------------------------------------

  function automatic string word_text(input int k);
    case (k)
      WORD_SRV_FLAG: return {string'("server_no_"), string'("context_takeover")};
      WORD_CLI_FLAG: return {string'("client_no_"), string'("context_takeover")};
      WORD_SRV_WIN:  return {string'("server_max_"), string'("window_bits")};
      WORD_CLI_WIN:  return {string'("client_max_"), string'("window_bits")};
      default:       return "permessage-deflate";
    endcase
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
  endfunction

  function automatic logic name_is(input int k, input logic [4:0] len);
    return name_cands[k] && (name_pos == len);
  endfunction

  task automatic begin_name(input ph_e ph);
    parse_ph    = ph;
    name_pos    = '0;
    name_cands  = ALL_CAND;
    name_broken = 1'b0;
  endtask

  task automatic clear_offer();
    begin_name(PH_EXT_NAME);
    win_target  = WIN_NONE;
    value_acc   = '0;
    offer_seen  = 1'b0;
    no_ctx_seen = '0;
    srv_bits    = WIN_DEF;
    cli_bits    = WIN_DEF;
  endtask

  // Narrow the candidate words by one more name character.
  task automatic feed_name(input logic [7:0] c, input logic is_ext);
    logic [7:0] lc;
    string      w;
    int         k;
    lc = fold_case(c);
    if (name_broken) begin
      name_cands = '0;
    end else if (is_ext) begin
      w = word_text(WORD_OFFER);
      if (name_pos >= EXT_LEN || w[int'(name_pos)] != lc) name_cands[OFFER_BIT] = 1'b0;
    end else begin
      for (k = WORD_SRV_FLAG; k <= WORD_CLI_WIN; k++) begin
        w = word_text(k);
        if (int'(name_pos) >= w.len() || w[int'(name_pos)] != lc) name_cands[k] = 1'b0;
      end
    end
    if (name_pos < POS_MAX) name_pos++;
  endtask

  task automatic take_flags();
    if (name_is(WORD_SRV_FLAG, FLAG_LEN)) no_ctx_seen[0] = 1'b1;
    if (name_is(WORD_CLI_FLAG, FLAG_LEN)) no_ctx_seen[1] = 1'b1;
  endtask

  // A window value counts only when it lies in the legal range.
  task automatic store_value();
    if (value_acc >= WIN_MIN && value_acc <= WIN_MAX) begin
      if (win_target == WIN_SRV) srv_bits = value_acc[3:0];
      else if (win_target == WIN_CLI) cli_bits = value_acc[3:0];
    end
    win_target = WIN_NONE;
    value_acc  = '0;
  endtask

  task automatic after_value(input logic [7:0] c);
    if (c == CH_COMMA) parse_ph = PH_DONE;
    else if (c == CH_SEMI) begin_name(PH_PRM_NAME);
    else parse_ph = PH_PRM_SKIP;
  endtask

  // Advance the parser by one accepted byte and queue the result on the last.
  task automatic parse_byte(input logic [7:0] c, input logic last);
    logic digit;
    int   v;
    res_t r;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (parse_ph)
      PH_EXT_NAME: begin
        if (c == CH_COMMA) begin
          if (name_is(OFFER_BIT, EXT_LEN)) begin
            offer_seen = 1'b1;
            parse_ph   = PH_DONE;
          end else begin
            begin_name(PH_EXT_NAME);
          end
        end else if (c == CH_SEMI) begin
          if (name_is(OFFER_BIT, EXT_LEN)) begin
            offer_seen = 1'b1;
            begin_name(PH_PRM_NAME);
          end else begin
            parse_ph = PH_EXT_SKIP;
          end
        end else if (is_blank(c)) begin
          if (name_pos != 0) name_broken = 1'b1;
        end else begin
          feed_name(c, 1'b1);
        end
      end
      PH_EXT_SKIP: begin
        if (c == CH_COMMA) begin_name(PH_EXT_NAME);
      end
      PH_PRM_NAME: begin
        if (c == CH_COMMA) begin
          take_flags();
          parse_ph = PH_DONE;
        end else if (c == CH_SEMI) begin
          take_flags();
          begin_name(PH_PRM_NAME);
        end else if (c == CH_EQUAL) begin
          take_flags();
          value_acc = '0;
          if (name_is(WORD_SRV_WIN, WIN_LEN)) begin
            win_target = WIN_SRV;
            parse_ph   = PH_VAL_LEAD;
          end else if (name_is(WORD_CLI_WIN, WIN_LEN)) begin
            win_target = WIN_CLI;
            parse_ph   = PH_VAL_LEAD;
          end else begin
            win_target = WIN_NONE;
            parse_ph   = PH_PRM_SKIP;
          end
        end else if (is_blank(c)) begin
          if (name_pos != 0) name_broken = 1'b1;
        end else begin
          feed_name(c, 1'b0);
        end
      end
      PH_VAL_LEAD: begin
        if (!is_blank(c)) begin
          if (digit) begin
            value_acc = 5'(c - CH_ZERO);
            parse_ph  = PH_VAL_DIGITS;
          end else begin
            store_value();
            after_value(c);
          end
        end
      end
      PH_VAL_DIGITS: begin
        if (digit) begin
          v = int'(value_acc) * 10 + int'(c - CH_ZERO);
          value_acc = (v > int'(ACC_MAX)) ? ACC_MAX : 5'(v);
        end else begin
          store_value();
          after_value(c);
        end
      end
      PH_PRM_SKIP: begin
        if (c == CH_COMMA) parse_ph = PH_DONE;
        else if (c == CH_SEMI) begin_name(PH_PRM_NAME);
      end
      default: ;
    endcase

    if (last) begin
      // Close whatever token the value ended in.
      if (parse_ph == PH_EXT_NAME && name_is(OFFER_BIT, EXT_LEN)) offer_seen = 1'b1;
      else if (parse_ph == PH_PRM_NAME) take_flags();
      else if (parse_ph == PH_VAL_DIGITS) store_value();
      r.offer_found             = offer_seen;
      r.server_keeps_no_context = offer_seen & no_ctx_seen[0];
      r.client_keeps_no_context = offer_seen & no_ctx_seen[1];
      r.server_window_bits      = offer_seen ? srv_bits : WIN_DEF;
      r.client_window_bits      = offer_seen ? cli_bits : WIN_DEF;
      expected_offers.push_back(r);
      clear_offer();
    end
  endtask

  // --------------------------------------------------------------------------
  // Header value builder
  // --------------------------------------------------------------------------

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) hdr_bytes.push_back(s[i]);
  endtask

  task automatic put_blanks();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) hdr_bytes.push_back($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
  endtask

  // Known word in random case, now and then mangled so that it fails to match.
  task automatic put_word(input string w);
    int         i;
    int         pick;
    int         cut;
    logic [7:0] c;
    pick = $urandom_range(0, 15);
    cut  = $urandom_range(1, w.len() - 1);
    for (i = 0; i < w.len(); i++) begin
      c = w[i];
      if (c >= LOW_A && c <= LOW_Z && $urandom_range(0, 3) == 0) c = c - CASE_OFS;
      if (pick == 0 && i == cut) c = LOW_A + 8'($urandom_range(0, 25));
      if (pick == 1 && i == cut) hdr_bytes.push_back(CH_SPACE);
      if (!(pick == 2 && i == w.len() - 1)) hdr_bytes.push_back(c);
    end
    if (pick == 3) hdr_bytes.push_back(LOW_A + 8'($urandom_range(0, 25)));
    // An overlong name can run the position counter into its limit.
    if (pick == 4) repeat ($urandom_range(6, 16)) hdr_bytes.push_back(LOW_A);
  endtask

  task automatic put_number(input int v);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) hdr_bytes.push_back(CH_ZERO);
    put_text($sformatf("%0d", v));
  endtask

  task automatic put_value();
    put_blanks();
    case ($urandom_range(0, 9))
      0, 1, 2: put_number($urandom_range(8, 15));
      3:       put_number($urandom_range(0, 7));
      4:       put_number($urandom_range(16, 99));
      5:       repeat ($urandom_range(3, 8)) hdr_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      6:       ;
      7: begin
        hdr_bytes.push_back(CH_QUOTE);
        put_number($urandom_range(8, 15));
        hdr_bytes.push_back(CH_QUOTE);
      end
      8: begin
        put_number($urandom_range(8, 15));
        hdr_bytes.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
      end
      default: repeat ($urandom_range(1, 3)) hdr_bytes.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
    endcase
    put_blanks();
  endtask

  task automatic put_param();
    put_blanks();
    case ($urandom_range(0, 7))
      0, 1: begin
        put_word(word_text($urandom_range(WORD_SRV_FLAG, WORD_CLI_FLAG)));
        put_blanks();
        // A flag keeps counting when some value trails it.
        if ($urandom_range(0, 3) == 0) begin
          hdr_bytes.push_back(CH_EQUAL);
          put_value();
        end
      end
      2, 3, 4, 5: begin
        put_word(word_text($urandom_range(WORD_SRV_WIN, WORD_CLI_WIN)));
        put_blanks();
        if ($urandom_range(0, 5) != 0) begin
          hdr_bytes.push_back(CH_EQUAL);
          put_value();
        end
      end
      6: begin
        put_text($urandom_range(0, 1) ? "mode" : "server_max_window");
        if ($urandom_range(0, 1)) begin
          hdr_bytes.push_back(CH_EQUAL);
          put_value();
        end
      end
      default: if ($urandom_range(0, 1)) hdr_bytes.push_back(CH_EQUAL);
    endcase
    put_blanks();
  endtask

  task automatic put_extension(input logic deflate);
    put_blanks();
    if (deflate) begin
      put_word(word_text(WORD_OFFER));
    end else begin
      case ($urandom_range(0, 3))
        0:       put_text("x-webkit-deflate-frame");
        1:       put_text("permessage-bzip");
        2:       put_text("permessage-deflat");
        default: put_text("foo");
      endcase
    end
    put_blanks();
    repeat ($urandom_range(0, 3)) begin
      hdr_bytes.push_back(CH_SEMI);
      put_param();
    end
  endtask

  // Move the built value into the send queue with its last byte marked.
  task automatic commit_header();
    int        i;
    hdr_byte_t b;
    if (hdr_bytes.size() == 0) hdr_bytes.push_back(8'($urandom_range(0, 255)));
    for (i = 0; i < hdr_bytes.size(); i++) begin
      b.ch   = hdr_bytes[i];
      b.last = (i == hdr_bytes.size() - 1);
      pending_bytes.push_back(b);
    end
    hdr_bytes.delete();
    headers_built++;
  endtask

  task automatic build_header();
    int style;
    int keep;
    style = $urandom_range(0, 9);
    if (style < 7) begin
      // Offers, possibly behind other extensions and followed by more.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          put_extension(1'b0);
          hdr_bytes.push_back(CH_COMMA);
        end
      end
      put_extension($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 3) == 0) begin
        hdr_bytes.push_back(CH_COMMA);
        put_extension($urandom_range(0, 1));
      end
      // Some values stop partway, inside a name or a number.
      if (style == 6 && hdr_bytes.size() > 1) begin
        keep = $urandom_range(1, hdr_bytes.size());
        while (hdr_bytes.size() > keep) void'(hdr_bytes.pop_back());
      end
    end else begin
      // Byte noise with a share of separators and blanks.
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0:       hdr_bytes.push_back(CH_COMMA);
            1:       hdr_bytes.push_back(CH_SEMI);
            2:       hdr_bytes.push_back(CH_EQUAL);
            3:       hdr_bytes.push_back(CH_SPACE);
            default: hdr_bytes.push_back(CH_TAB);
          endcase
        end else begin
          hdr_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
    commit_header();
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: bursts of random length with random gaps.
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) begin
        parse_byte(byte_ch.char_in, byte_ch.last_byte);
        bytes_accepted++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (gap_left > 0 || pending_bytes.size() == 0) begin
          byte_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_byte = pending_bytes.pop_front();
          byte_ch.valid     <= 1'b1;
          byte_ch.char_in   <= next_byte.ch;
          byte_ch.last_byte <= next_byte.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and receiver stall pattern
  // --------------------------------------------------------------------------

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  int          ready_mode;
  int          mode_left;
  int          holdoff_left;
  logic        holdoff_done;
  logic        ready_next;
  int unsigned cycle_count;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_offers.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual found %0d bits %0d/%0d",
                     $time, result_ch.offer_found, result_ch.server_window_bits,
                     result_ch.client_window_bits);
        end else begin
          oldest_offer = expected_offers.pop_front();
          check_field("offer_found", oldest_offer.offer_found, result_ch.offer_found);
          check_field("server_keeps_no_context", oldest_offer.server_keeps_no_context,
                      result_ch.server_keeps_no_context);
          check_field("client_keeps_no_context", oldest_offer.client_keeps_no_context,
                      result_ch.client_keeps_no_context);
          check_field("server_window_bits", oldest_offer.server_window_bits,
                      result_ch.server_window_bits);
          check_field("client_window_bits", oldest_offer.client_window_bits,
                      result_ch.client_window_bits);
        end
      end

      // One long hold-off lets the result queue fill and stall the input.
      cycle_count++;
      if (!holdoff_done && bytes_accepted >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 60);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0:       ready_next = 1'b1;
        1:       ready_next = $urandom_range(0, 1);
        2:       ready_next = (cycle_count % 4 == 0);
        default: ready_next = ($urandom_range(0, 7) == 0);
      endcase
      if (holdoff_left > 0) begin
        ready_next = 1'b0;
        holdoff_left--;
      end
      result_ch.ready <= ready_next;
    end
  end

  // Watchdog on cycles without any transaction.
  int idle_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.char_in   = '0;
    byte_ch.last_byte = 1'b0;
    result_ch.ready   = 1'b0;
    headers_built     = 0;
    bytes_accepted    = 0;
    error_count       = 0;
    burst_left        = 0;
    gap_left          = 0;
    ready_mode        = 0;
    mode_left         = 0;
    holdoff_left      = 0;
    holdoff_done      = 1'b0;
    cycle_count       = 0;
    idle_cycles       = 0;
    clear_offer();

    // Directed values: byte extremes, a bare offer in mixed case, separators.
    hdr_bytes.push_back(8'h00);
    commit_header();
    hdr_bytes.push_back(8'hFF);
    commit_header();
    put_text("PerMessage-Deflate");
    commit_header();
    hdr_bytes.push_back(CH_COMMA);
    commit_header();
    hdr_bytes.push_back(CH_TAB);
    hdr_bytes.push_back(CH_SEMI);
    commit_header();

    total_bytes = pending_bytes.size() + RANDOM_BYTES;
    while (pending_bytes.size() < total_bytes || headers_built < MIN_HEADERS) build_header();
    total_bytes = pending_bytes.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_accepted < total_bytes || expected_offers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && expected_offers.size() == 0) begin
      $display("status: pass");
    end else begin
      if (expected_offers.size() != 0)
        $display("%0t: results missing, expected %0d more, actual 0",
                 $time, expected_offers.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
